[design/sdm_pkg.sv]
package sdm_pkg;

    localparam int MAX_BODIES_DEF  = 8;
    localparam int JOINT_COUNT_DEF = 32;

    localparam int POS_W    = 16;
    localparam int CONF_W   = 2;
    localparam int JOINT_W  = 5;
    localparam int THR_W    = 11;
    localparam int THR_SQ_W = 22;
    localparam int MAG_W    = 16;
    localparam int SQ_W     = 32;
    localparam int SUM_W    = 34;
    localparam int ID_OUT_W = 4;
    localparam int ADDR_W   = 4;
    localparam int DATA_W   = 32;

    localparam logic [CONF_W-1:0] CONF_MEDIUM = 2'd2;
    localparam logic [SUM_W-1:0]  DIST_CAP_SQ = 34'd1000000;

    localparam logic [1:0] REG_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_SIMPLE    = 2'd1;
    localparam logic [1:0] REG_CHEST     = 2'd2;

    localparam logic [THR_W-1:0]    THRESHOLD_RST = 11'd300;
    localparam logic [THR_SQ_W-1:0] THR_SQ_RST    = 22'd90000;
    localparam logic [JOINT_W-1:0]  CHEST_RST     = 5'd2;

    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] z;
        logic [CONF_W-1:0]       conf;
    } joint_entry_t;

    typedef struct packed {
        logic               frame_start;
        logic [JOINT_W-1:0] joint;
        joint_entry_t       entry;
        logic               compare;
        logic               in_range;
        logic               last;
    } token_t;

endpackage

[design/sdm_cell.sv]
module sdm_cell
    import sdm_pkg::*;
#(
    parameter int JOINT_COUNT = JOINT_COUNT_DEF,
    parameter int ID_W        = 4,
    parameter int CELL_ID     = 0
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  token_t              tok_in,
    input  logic                tok_in_valid,
    input  logic [ID_W-1:0]     count_in,
    input  logic [THR_SQ_W-1:0] thr_sq,
    input  logic [ID_W-1:0]     res_in,
    output token_t              tok_out,
    output logic                tok_out_valid,
    output logic [ID_W-1:0]     count_out,
    output logic [ID_W-1:0]     res_out
);

    localparam int JIDX_W = (JOINT_COUNT > 1) ? $clog2(JOINT_COUNT) : 1;
    localparam logic [ID_W-1:0] SLOT  = ID_W'(CELL_ID);
    localparam logic [ID_W-1:0] MY_ID = ID_W'(CELL_ID + 1);

    function automatic logic [MAG_W-1:0] abs_diff(input logic signed [POS_W-1:0] a,
                                                  input logic signed [POS_W-1:0] b);
        logic signed [POS_W:0] d;
        logic [POS_W:0]        n;
        d = {a[POS_W-1], a} - {b[POS_W-1], b};
        n = -d;
        return d[POS_W] ? n[MAG_W-1:0] : d[MAG_W-1:0];
    endfunction

    joint_entry_t joint_mem [JOINT_COUNT];

    token_t            tok_reg;
    logic              tok_valid_reg;
    logic [ID_W-1:0]   count_reg;

    joint_entry_t      rd_reg;
    joint_entry_t      pos1_reg;
    logic              en1_reg;
    logic              last1_reg;
    logic              v1_reg;

    logic [SQ_W-1:0]   sqx_reg;
    logic [SQ_W-1:0]   sqy_reg;
    logic [SQ_W-1:0]   sqz_reg;
    logic              en2_reg;
    logic              last2_reg;
    logic              v2_reg;

    logic              flag_reg;
    logic              flag_next;
    logic [ID_W-1:0]   res_reg;
    logic [ID_W-1:0]   res_next;

    logic [JIDX_W-1:0] jidx;
    logic              en0;
    logic              wr0;
    logic [MAG_W-1:0]  mag_x;
    logic [MAG_W-1:0]  mag_y;
    logic [MAG_W-1:0]  mag_z;
    logic [SUM_W-1:0]  dist_sq;
    logic [SUM_W-1:0]  dist_capped;
    logic              hit;
    logic              flag_now;

    assign tok_out       = tok_reg;
    assign tok_out_valid = tok_valid_reg;
    assign count_out     = count_reg;
    assign res_out       = res_reg;

    // stage 0: read or write this body's joint slot
    assign jidx = tok_reg.joint[JIDX_W-1:0];
    assign en0  = tok_reg.compare && (SLOT < count_reg);
    assign wr0  = tok_reg.in_range && (SLOT == count_reg);

    always_ff @(posedge clk)
    begin
        if (tok_valid_reg && wr0)
        begin
            joint_mem[jidx] <= tok_reg.entry;
        end
        rd_reg <= joint_mem[jidx];
    end

    // stage 1: squared axis distances
    assign mag_x = abs_diff(rd_reg.x, pos1_reg.x);
    assign mag_y = abs_diff(rd_reg.y, pos1_reg.y);
    assign mag_z = abs_diff(rd_reg.z, pos1_reg.z);

    // stage 2: sum, cap, threshold
    assign dist_sq     = SUM_W'(sqx_reg) + SUM_W'(sqy_reg) + SUM_W'(sqz_reg);
    assign dist_capped = (dist_sq > DIST_CAP_SQ) ? DIST_CAP_SQ : dist_sq;
    assign hit         = en2_reg && (dist_capped < SUM_W'(thr_sq));
    assign flag_now    = flag_reg | hit;

    always_comb
    begin
        flag_next = flag_reg;
        res_next  = res_reg;
        if (v2_reg)
        begin
            flag_next = last2_reg ? 1'b0 : flag_now;
            res_next  = flag_now ? MY_ID : res_in;
        end
        if (tok_valid_reg && tok_reg.frame_start)
        begin
            flag_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        tok_reg   <= tok_in;
        count_reg <= count_in;
        pos1_reg  <= tok_reg.entry;
        en1_reg   <= en0;
        last1_reg <= tok_reg.last;
        sqx_reg   <= SQ_W'(mag_x) * SQ_W'(mag_x);
        sqy_reg   <= SQ_W'(mag_y) * SQ_W'(mag_y);
        sqz_reg   <= SQ_W'(mag_z) * SQ_W'(mag_z);
        en2_reg   <= en1_reg && (rd_reg.conf == CONF_MEDIUM);
        last2_reg <= last1_reg;
        res_reg   <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_valid_reg <= 1'b0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            flag_reg      <= 1'b0;
        end
        else
        begin
            tok_valid_reg <= tok_in_valid;
            v1_reg        <= tok_valid_reg;
            v2_reg        <= v1_reg;
            flag_reg      <= flag_next;
        end
    end

endmodule

[design/skeleton_duplicate_merge.sv]
// skeleton duplicate merge
// items arrive one joint each on item_valid / item_ready, carrying the joint
// index, position, confidence and frame_start / last_joint marks. each stored
// body lives in one cell of a chain; the item walks the chain one cell per
// cycle and every cell holding a body compares it with its own copy of that joint.
// one item is in flight at a time: item_ready stays low from acceptance
// until the item has passed the cell chain plus the read, square and
// compare stages of the last cell. a last joint's outcome then waits in a
// pending register, with item_ready still low, and shows as a result item
// on result_valid / result_ready: a new id, a duplicate id, or the full flag.
// the result waits in an output register, so while the receiver stalls the
// next item is still taken; a further result waits until the slot frees.
// configuration uses the apb port (threshold at 0x0, simple mode at 0x4,
// chest joint at 0x8), written by the user only while the block is idle;
// the block does not enforce this. reset empties the body table count,
// clears match flags and loads register defaults; joint storage is not cleared
module skeleton_duplicate_merge
    import sdm_pkg::*;
#(
    parameter int MAX_BODIES  = MAX_BODIES_DEF,
    parameter int JOINT_COUNT = JOINT_COUNT_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,

    input  logic                       item_valid,
    output logic                       item_ready,
    input  logic                       frame_start,
    input  logic [JOINT_W-1:0]         joint_index,
    input  logic signed [POS_W-1:0]    pos_x,
    input  logic signed [POS_W-1:0]    pos_y,
    input  logic signed [POS_W-1:0]    pos_z,
    input  logic [CONF_W-1:0]          confidence,
    input  logic                       last_joint,

    output logic                       result_valid,
    input  logic                       result_ready,
    output logic [ID_OUT_W-1:0]        new_body_id,
    output logic [ID_OUT_W-1:0]        duplicate_of,
    output logic                       table_full,

    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ADDR_W-1:0]          paddr,
    input  logic [DATA_W-1:0]          pwdata,
    output logic [DATA_W-1:0]          prdata,
    output logic                       pready
);

    localparam int ID_W   = $clog2(MAX_BODIES + 1);
    localparam int RUN_N  = MAX_BODIES + 2;
    localparam int CNT_W  = $clog2(RUN_N + 1);
    localparam logic [ID_W-1:0]  MAX_ID   = ID_W'(MAX_BODIES);
    localparam logic [CNT_W-1:0] RUN_LAST = CNT_W'(RUN_N);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_HOLD = 3'b100
    } state_t;

    state_t                state_reg;
    state_t                state_next;
    logic [CNT_W-1:0]      cyc_reg;
    logic [ID_W-1:0]       count_reg;
    logic                  last_reg;

    logic [ID_W-1:0]       pend_new_reg;
    logic [ID_W-1:0]       pend_dup_reg;
    logic                  pend_full_reg;

    logic                  out_valid_reg;
    logic [ID_OUT_W-1:0]   out_new_reg;
    logic [ID_OUT_W-1:0]   out_dup_reg;
    logic                  out_full_reg;

    logic [THR_W-1:0]      threshold_reg;
    logic                  simple_reg;
    logic [JOINT_W-1:0]    chest_reg;
    logic [THR_SQ_W-1:0]   thr_sq_reg;

    logic                  accept;
    logic                  done;
    logic                  load_out;
    logic                  cfg_wr;
    logic                  in_range;
    logic [ID_W-1:0]       dup_id;
    token_t                tok_head;

    token_t                tok_chain [MAX_BODIES];
    logic                  tv_chain  [MAX_BODIES];
    logic [ID_W-1:0]       cnt_chain [MAX_BODIES];
    logic [ID_W-1:0]       res_chain [MAX_BODIES+1];

    assign item_ready   = (state_reg == S_IDLE);
    assign accept       = item_valid && item_ready;
    assign done         = (state_reg == S_RUN) && (cyc_reg == RUN_LAST);
    assign load_out     = (state_reg == S_HOLD) && (!out_valid_reg || result_ready);
    assign dup_id       = res_chain[MAX_BODIES];

    assign result_valid = out_valid_reg;
    assign new_body_id  = out_new_reg;
    assign duplicate_of = out_dup_reg;
    assign table_full   = out_full_reg;

    // item entering the chain
    assign in_range = {1'b0, joint_index} < (JOINT_W+1)'(JOINT_COUNT);

    always_comb
    begin
        tok_head.frame_start = frame_start;
        tok_head.joint       = joint_index;
        tok_head.entry.x     = pos_x;
        tok_head.entry.y     = pos_y;
        tok_head.entry.z     = pos_z;
        tok_head.entry.conf  = confidence;
        tok_head.in_range    = in_range;
        tok_head.last        = last_joint;
        tok_head.compare     = in_range && (confidence == CONF_MEDIUM) &&
                               (!simple_reg || (joint_index == chest_reg));
    end

    assign tok_chain[0] = tok_head;
    assign tv_chain[0]  = accept;
    assign cnt_chain[0] = frame_start ? '0 : count_reg;
    assign res_chain[0] = '0;

    for (genvar b = 0; b < MAX_BODIES; b++)
    begin : g_cell
        if (b < MAX_BODIES - 1)
        begin : g_mid
            sdm_cell #(
                .JOINT_COUNT (JOINT_COUNT),
                .ID_W        (ID_W),
                .CELL_ID     (b)
            ) u_cell (
                .clk           (clk),
                .rst_n         (rst_n),
                .tok_in        (tok_chain[b]),
                .tok_in_valid  (tv_chain[b]),
                .count_in      (cnt_chain[b]),
                .thr_sq        (thr_sq_reg),
                .res_in        (res_chain[b]),
                .tok_out       (tok_chain[b+1]),
                .tok_out_valid (tv_chain[b+1]),
                .count_out     (cnt_chain[b+1]),
                .res_out       (res_chain[b+1])
            );
        end
        else
        begin : g_tail
            sdm_cell #(
                .JOINT_COUNT (JOINT_COUNT),
                .ID_W        (ID_W),
                .CELL_ID     (b)
            ) u_cell (
                .clk           (clk),
                .rst_n         (rst_n),
                .tok_in        (tok_chain[b]),
                .tok_in_valid  (tv_chain[b]),
                .count_in      (cnt_chain[b]),
                .thr_sq        (thr_sq_reg),
                .res_in        (res_chain[b]),
                .tok_out       (),
                .tok_out_valid (),
                .count_out     (),
                .res_out       (res_chain[b+1])
            );
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_RUN;
                end
            end
            S_RUN:
            begin
                if (done)
                begin
                    state_next = last_reg ? S_HOLD : S_IDLE;
                end
            end
            S_HOLD:
            begin
                if (load_out)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cyc_reg       <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                cyc_reg <= '0;
                if (frame_start)
                begin
                    count_reg <= '0;
                end
            end
            else if (state_reg == S_RUN)
            begin
                cyc_reg <= cyc_reg + 1'b1;
            end
            if (done && last_reg && (dup_id == '0) && (count_reg < MAX_ID))
            begin
                count_reg <= count_reg + 1'b1;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            last_reg <= last_joint;
        end
        if (done)
        begin
            pend_dup_reg  <= dup_id;
            pend_new_reg  <= '0;
            pend_full_reg <= 1'b0;
            if (dup_id == '0)
            begin
                if (count_reg < MAX_ID)
                begin
                    pend_new_reg <= count_reg + 1'b1;
                end
                else
                begin
                    pend_full_reg <= 1'b1;
                end
            end
        end
        if (load_out)
        begin
            out_new_reg  <= ID_OUT_W'(pend_new_reg);
            out_dup_reg  <= ID_OUT_W'(pend_dup_reg);
            out_full_reg <= pend_full_reg;
        end
    end

    // configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RST;
            simple_reg    <= 1'b0;
            chest_reg     <= CHEST_RST;
            thr_sq_reg    <= THR_SQ_RST;
        end
        else
        begin
            thr_sq_reg <= THR_SQ_W'(threshold_reg) * THR_SQ_W'(threshold_reg);
            if (cfg_wr)
            begin
                case (paddr[3:2])
                    REG_THRESHOLD: threshold_reg <= pwdata[THR_W-1:0];
                    REG_SIMPLE:    simple_reg    <= pwdata[0];
                    REG_CHEST:     chest_reg     <= pwdata[JOINT_W-1:0];
                    default:       ;
                endcase
            end
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_THRESHOLD: prdata = DATA_W'(threshold_reg);
            REG_SIMPLE:    prdata = DATA_W'(simple_reg);
            REG_CHEST:     prdata = DATA_W'(chest_reg);
            default:       prdata = '0;
        endcase
    end

endmodule

[design/sdm_checker.sv]
module sdm_checker
    import sdm_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    item_valid,
    input logic                    item_ready,
    input logic                    frame_start,
    input logic [JOINT_W-1:0]      joint_index,
    input logic signed [POS_W-1:0] pos_x,
    input logic signed [POS_W-1:0] pos_y,
    input logic signed [POS_W-1:0] pos_z,
    input logic [CONF_W-1:0]       confidence,
    input logic                    last_joint,
    input logic                    result_valid,
    input logic                    result_ready,
    input logic [ID_OUT_W-1:0]     new_body_id,
    input logic [ID_OUT_W-1:0]     duplicate_of,
    input logic                    table_full,
    input logic                    psel,
    input logic                    penable,
    input logic                    pwrite,
    input logic [ADDR_W-1:0]       paddr,
    input logic [DATA_W-1:0]       pwdata,
    input logic [DATA_W-1:0]       prdata,
    input logic                    pready
);

    // a stalled result holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=>
            result_valid && $stable(new_body_id) && $stable(duplicate_of) &&
            $stable(table_full))
        else $error("stalled result changed");

    // a result is a new body, a duplicate or a full table, never two of them
    a_one_outcome: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |->
            !((new_body_id != '0) && (duplicate_of != '0)) &&
            !(table_full && ((new_body_id != '0) || (duplicate_of != '0))))
        else $error("result carries more than one outcome");

    // one item at a time: busy right after an accept
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !item_ready)
        else $error("item taken while the chain is busy");

    // no result can come out of the chain in the cycle after an item enters
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !$rose(result_valid))
        else $error("result appeared too early");

    // the apb port never waits
    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable |-> pready)
        else $error("apb access stalled");

endmodule

bind skeleton_duplicate_merge sdm_checker u_sdm_checker (.*);
